### hw/rtl/srt_pkg.sv
`default_nettype none

package srt_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int SLOT_W    = 4;
  localparam int VAL_W     = 16;
  localparam int TIME_W    = 32;
  localparam int CNT_W     = 5;
  localparam int ACC_W     = 48;
  localparam int CMP_W     = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  localparam logic [TIME_W-1:0] TIME_MAX  = '1;
  localparam logic [ACC_W-1:0]  ACC_MAX   = '1;
  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TURN,
    ST_WAIT,
    ST_COMMIT
  } srt_state_t;

  // Best candidate so far, passed from cell to cell.
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  rem;
    logic [VAL_W-1:0]  arr;
    logic [VAL_W-1:0]  burst;
  } srt_token_t;

  typedef struct packed {
    logic load;
    logic dec;
  } srt_cell_ctrl_t;

  typedef struct packed {
    logic ready;
    logic turn;
    logic wait_en;
    logic commit;
  } srt_fsm_out_t;

endpackage

`default_nettype wire

### hw/rtl/srt_cell.sv
`default_nettype none

module srt_cell
  import srt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [IDX_W-1:0]     cell_index,
  input  wire srt_cell_ctrl_t       ctrl,
  input  wire logic [VAL_W-1:0]     wr_arrival,
  input  wire logic [VAL_W-1:0]     wr_burst,
  input  wire logic [TIME_W-1:0]    clock_time,
  input  wire srt_token_t           tok_in,
  output srt_token_t                tok_out,
  output logic                      pending
);

  logic [VAL_W-1:0] arrival;
  logic [VAL_W-1:0] burst;
  logic [VAL_W-1:0] remaining;
  logic             loaded;
  logic             done;
  logic             eligible;
  logic             take;

  assign pending  = loaded & ~done;
  assign eligible = pending & (TIME_W'(arrival) <= clock_time);
  // <= lets a later cell win a tie
  assign take     = eligible & (~tok_in.found | (remaining <= tok_in.rem));

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
      done   <= 1'b0;
    end else if (ctrl.load) begin
      loaded <= 1'b1;
      done   <= 1'b0;
    end else if (ctrl.dec && remaining <= VAL_W'(1)) begin
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      arrival   <= wr_arrival;
      burst     <= wr_burst;
      remaining <= wr_burst;
    end else if (ctrl.dec && remaining != '0) begin
      remaining <= remaining - VAL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_out <= '{found: 1'b1, idx: cell_index, rem: remaining, arr: arrival, burst: burst};
    end else begin
      tok_out <= tok_in;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/srt_ctrl.sv
`default_nettype none

module srt_ctrl
  import srt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    accept,
  input  wire logic    operation,
  input  wire logic    out_free,
  output srt_fsm_out_t fsm
);

  srt_state_t       state;
  srt_state_t       state_next;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          state_next = (operation == OP_TICK) ? ST_SCAN : ST_COMMIT;
        end
      end
      ST_SCAN: begin
        cnt_next = cnt + IDX_W'(1);
        if (cnt == IDX_W'(MAX_TASKS - 1)) begin
          state_next = ST_TURN;
        end
      end
      ST_TURN:   state_next = ST_WAIT;
      ST_WAIT:   state_next = ST_COMMIT;
      ST_COMMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    fsm = '0;
    unique case (state)
      ST_IDLE:   fsm.ready   = 1'b1;
      ST_SCAN:   fsm.ready   = 1'b0;
      ST_TURN:   fsm.turn    = 1'b1;
      ST_WAIT:   fsm.wait_en = 1'b1;
      ST_COMMIT: fsm.commit  = out_free;
      default:   fsm = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/shortest_remaining_time_scheduler.sv
`default_nettype none

// Preemptive shortest-remaining-time-first scheduler over MAX_TASKS task slots.
// Each request is a load (write a slot with arrival time and burst length; a
// zero burst is stored as one, a slot at or beyond MAX_TASKS is ignored) or a
// tick (run the eligible task with least remaining time, highest slot on a tie,
// then advance time). Exactly one result comes back per request, carrying the
// chosen slot, the finish data of a task that completed on this tick, and the
// saturating time, finish count and turnaround and wait totals. The slots sit in
// a row of cells; a best-candidate token walks the row one cell per clock. A tick
// goes through an accept step, a scan while the token passes the row, then
// turnaround, wait and commit stages; a load goes from accept straight to commit.
// The result sits in an output register, so the block returns to ready as soon
// as that register is free. After reset every slot is empty and the block is
// ready at once.
module shortest_remaining_time_scheduler
  import srt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [3:0] task_slot, [19:4] task_arrival, [35:20] task_burst, [39:36] zero
  input  wire logic [39:0]  s_tdata,
  // [0] operation
  input  wire logic [0:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [0] ran_task, [4:1] chosen_slot, [5] task_finished, [37:6] finish_turnaround,
  // [69:38] finish_wait, [101:70] time_now, [106:102] finished_count,
  // [154:107] turnaround_sum, [202:155] wait_sum, [203] all_finished, [207:204] zero
  output logic [207:0]      m_tdata
);

  // Input field unpacking
  logic [SLOT_W-1:0] in_slot;
  logic [VAL_W-1:0]  in_arrival;
  logic [VAL_W-1:0]  in_burst;
  logic [VAL_W-1:0]  wr_burst;
  logic              accept;
  logic              out_free;
  srt_fsm_out_t      fsm;

  assign in_slot    = s_tdata[3:0];
  assign in_arrival = s_tdata[19:4];
  assign in_burst   = s_tdata[35:20];
  assign wr_burst   = (in_burst == '0) ? VAL_W'(1) : in_burst;
  // Hold off requests while reset is asserted
  assign s_tready   = fsm.ready & ~rst;
  assign accept     = s_tvalid & s_tready;
  assign out_free   = ~m_tvalid | m_tready;

  srt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (s_tuser[0]),
    .out_free  (out_free),
    .fsm       (fsm)
  );

  // Global state
  logic              op_reg;
  logic [TIME_W-1:0] clock_time;
  logic [CNT_W-1:0]  done_total;
  logic [ACC_W-1:0]  turnaround_acc;
  logic [ACC_W-1:0]  wait_acc;
  logic [TIME_W-1:0] tat;
  logic [TIME_W-1:0] wt;

  // Cell row; token enters empty at cell 0 and leaves the last cell as the winner
  srt_token_t           tok [MAX_TASKS+1];
  srt_token_t           win;
  logic [MAX_TASKS-1:0] pending_vec;
  logic [MAX_TASKS-1:0] fin_vec;
  logic                 is_tick;
  logic                 finishing;

  assign tok[0]    = '0;
  assign win       = tok[MAX_TASKS];
  assign is_tick   = (op_reg == OP_TICK);
  // remaining never drops below one on a pending task, so one more step ends it
  assign finishing = is_tick & win.found & (win.rem <= VAL_W'(1));

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    srt_cell_ctrl_t cctrl;

    assign cctrl.load = accept & (s_tuser[0] == OP_LOAD) & (CMP_W'(in_slot) == CMP_W'(i));
    assign cctrl.dec  = fsm.commit & is_tick & win.found & (win.idx == IDX_W'(i));
    assign fin_vec[i] = finishing & (win.idx == IDX_W'(i));

    srt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_W'(i)),
      .ctrl       (cctrl),
      .wr_arrival (in_arrival),
      .wr_burst   (wr_burst),
      .clock_time (clock_time),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1]),
      .pending    (pending_vec[i])
    );
  end

  // Latch the kind of request for the rest of its run
  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg <= s_tuser[0];
    end
  end

  // Turnaround against the advanced (saturating) time, then the wait from it
  always_ff @(posedge clk) begin
    if (fsm.turn) begin
      tat <= clock_time - TIME_W'(win.arr) + TIME_W'(clock_time != TIME_MAX);
    end
    if (fsm.wait_en) begin
      wt <= (tat >= TIME_W'(win.burst)) ? tat - TIME_W'(win.burst) : '0;
    end
  end

  // Commit values
  logic [TIME_W-1:0] time_next;
  logic [CNT_W-1:0]  count_next;
  logic [ACC_W:0]    tsum_raw;
  logic [ACC_W:0]    wsum_raw;
  logic [ACC_W-1:0]  tsum_next;
  logic [ACC_W-1:0]  wsum_next;
  logic [IDX_W+SLOT_W-1:0] idx_ext;

  assign tsum_raw = {1'b0, turnaround_acc} + (ACC_W+1)'(tat);
  assign wsum_raw = {1'b0, wait_acc} + (ACC_W+1)'(wt);
  assign idx_ext  = {{SLOT_W{1'b0}}, win.idx};

  always_comb begin
    time_next  = clock_time;
    count_next = done_total;
    tsum_next  = turnaround_acc;
    wsum_next  = wait_acc;
    if (is_tick && clock_time != TIME_MAX) begin
      time_next = clock_time + TIME_W'(1);
    end
    if (finishing) begin
      if (done_total != COUNT_MAX) begin
        count_next = done_total + CNT_W'(1);
      end
      tsum_next = tsum_raw[ACC_W] ? ACC_MAX : tsum_raw[ACC_W-1:0];
      wsum_next = wsum_raw[ACC_W] ? ACC_MAX : wsum_raw[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_time     <= '0;
      done_total     <= '0;
      turnaround_acc <= '0;
      wait_acc       <= '0;
    end else if (fsm.commit) begin
      clock_time     <= time_next;
      done_total     <= count_next;
      turnaround_acc <= tsum_next;
      wait_acc       <= wsum_next;
    end
  end

  // Output register; hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fsm.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fsm.commit) begin
      m_tdata[0]       <= is_tick & win.found;
      m_tdata[4:1]     <= (is_tick & win.found) ? idx_ext[SLOT_W-1:0] : '0;
      m_tdata[5]       <= finishing;
      m_tdata[37:6]    <= finishing ? tat : '0;
      m_tdata[69:38]   <= finishing ? wt : '0;
      m_tdata[101:70]  <= time_next;
      m_tdata[106:102] <= count_next;
      m_tdata[154:107] <= tsum_next;
      m_tdata[202:155] <= wsum_next;
      m_tdata[203]     <= ~|(pending_vec & ~fin_vec);
      m_tdata[207:204] <= '0;
    end
  end

`ifndef ASSERT_OFF
  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(fsm.commit))
    else $error("result appeared without a commit");

  a_time_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> clock_time >= $past(clock_time))
    else $error("time went backward");

  a_winner_pending: assert property (@(posedge clk) disable iff (rst)
    fsm.commit && is_tick && win.found |-> pending_vec[win.idx])
    else $error("chosen slot is not a pending task");

  a_finish_counts: assert property (@(posedge clk) disable iff (rst)
    fsm.commit && finishing && done_total != COUNT_MAX |=>
      done_total == $past(done_total) + CNT_W'(1))
    else $error("finish count did not advance");
`endif

endmodule

`default_nettype wire
